// ===== src/jhmp_pkg.sv =====
// ----------------------------------------------------------------------------
// jhmp_pkg
// Shared types and constants for the JPEG header marker parser.
// ----------------------------------------------------------------------------
`default_nettype none

package jhmp_pkg;

    localparam int HLEN_W = 20;

    // marker codes following an 0xff byte
    localparam logic [7:0] BYTE_FF    = 8'hff;
    localparam logic [7:0] MARKER_DQT = 8'hdb;
    localparam logic [7:0] MARKER_DHT = 8'hc4;
    localparam logic [7:0] MARKER_SOF = 8'hc0;
    localparam logic [7:0] MARKER_DRI = 8'hdd;
    localparam logic [7:0] MARKER_SOS = 8'hda;
    localparam logic [7:0] MARKER_EOI = 8'hd9;

    localparam logic [7:0] SAMP_422 = 8'h21;
    localparam logic [7:0] SAMP_420 = 8'h22;

    localparam logic [7:0] TABLE_LEN_8BIT  = 8'd64;
    localparam logic [7:0] TABLE_LEN_16BIT = 8'd128;

    typedef struct packed {
        logic              table_byte_valid;
        logic              table_select;
        logic [6:0]        table_position;
        logic [7:0]        table_value;
        logic              header_done;
        logic              scan_found;
        logic [15:0]       frame_width;
        logic [15:0]       frame_height;
        logic              sampling_type;
        logic [15:0]       restart_interval;
        logic [3:0]        table_precision;
        logic [HLEN_W-1:0] header_length;
    } t_result;

endpackage

`default_nettype wire

// ===== src/jpeg_header_marker_parser.sv =====
// ----------------------------------------------------------------------------
// jpeg_header_marker_parser
// Scans a JPEG frame one byte per beat, streams quantisation table bytes and
// reports a header summary at SOS, EOI or the end of the frame.
// ----------------------------------------------------------------------------
// a byte's result passes through the input register, then the result register
// throughput: 1 byte per cycle, set by the single-step marker state machine,
// while the result register can take each result; a byte that yields nothing
// leaves the input register without waiting on the output side
// reset (synchronous, active low) empties both registers and clears the
// parse state to idle scanning
`default_nettype none

module jpeg_header_marker_parser #(
    parameter int OFFSET_BITS = 20
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_frame_start,
    input  wire         i_frame_end,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_table_byte_valid,
    output logic        o_table_select,
    output logic [6:0]  o_table_position,
    output logic [7:0]  o_table_value,
    output logic        o_header_done,
    output logic        o_scan_found,
    output logic [15:0] o_frame_width,
    output logic [15:0] o_frame_height,
    output logic        o_sampling_type,
    output logic [15:0] o_restart_interval,
    output logic [3:0]  o_table_precision,
    output logic [19:0] o_header_length
);

    logic              r_in_valid;
    logic [7:0]        r_data_byte;
    logic              r_frame_start;
    logic              r_frame_end;

    logic              w_res_valid;
    logic              w_buf_ready;
    logic              w_step;
    jhmp_pkg::t_result w_res;
    jhmp_pkg::t_result w_out;

    // a byte moves on when it yields no beat or the result register can take it
    assign w_step     = r_in_valid && (!w_res_valid || w_buf_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data_byte   <= i_data_byte;
            r_frame_start <= i_frame_start;
            r_frame_end   <= i_frame_end;
        end
    end

    jhmp_parse #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_data_byte   (r_data_byte),
        .i_frame_start (r_frame_start),
        .i_frame_end   (r_frame_end),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    jhmp_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid && w_res_valid),
        .o_load_ready (w_buf_ready),
        .i_load       (w_res),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_res        (w_out)
    );

    assign o_table_byte_valid = w_out.table_byte_valid;
    assign o_table_select     = w_out.table_select;
    assign o_table_position   = w_out.table_position;
    assign o_table_value      = w_out.table_value;
    assign o_header_done      = w_out.header_done;
    assign o_scan_found       = w_out.scan_found;
    assign o_frame_width      = w_out.frame_width;
    assign o_frame_height     = w_out.frame_height;
    assign o_sampling_type    = w_out.sampling_type;
    assign o_restart_interval = w_out.restart_interval;
    assign o_table_precision  = w_out.table_precision;
    assign o_header_length    = w_out.header_length;

`ifndef SYNTHESIS
    a_beat_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_table_byte_valid || o_header_done))
        else $error("result beat carries neither table byte nor summary");

    a_table_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_table_byte_valid) |->
        (!o_table_select && o_table_position == 7'd0 && o_table_value == 8'd0))
        else $error("table fields set without a table byte");

    a_summary_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_header_done) |->
        (!o_scan_found && o_frame_width == 16'd0 && o_frame_height == 16'd0 &&
         !o_sampling_type && o_restart_interval == 16'd0 &&
         o_table_precision == 4'd0 && o_header_length == 20'd0))
        else $error("summary fields set without header done");

    a_length_needs_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_scan_found) |-> (o_header_length == 20'd0))
        else $error("header length set without SOS");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== src/jhmp_parse.sv =====
// ----------------------------------------------------------------------------
// jhmp_parse
// Marker state machine: consumes one registered frame byte per step and
// forms the result for that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jhmp_parse #(
    parameter int OFFSET_BITS = 20
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_step,
    input  wire  [7:0]            i_data_byte,
    input  wire                   i_frame_start,
    input  wire                   i_frame_end,
    output logic                  o_res_valid,
    output jhmp_pkg::t_result     o_res
);

    localparam logic [3:0] MODE_SCAN  = 4'd0;
    localparam logic [3:0] MODE_MARK  = 4'd1;
    localparam logic [3:0] MODE_DQT   = 4'd2;
    localparam logic [3:0] MODE_TABLE = 4'd3;
    localparam logic [3:0] MODE_DHT   = 4'd4;
    localparam logic [3:0] MODE_SKIP  = 4'd5;
    localparam logic [3:0] MODE_SOF   = 4'd6;
    localparam logic [3:0] MODE_DRI   = 4'd7;
    localparam logic [3:0] MODE_SOS   = 4'd8;

    localparam int EXT_W = (OFFSET_BITS > jhmp_pkg::HLEN_W) ? OFFSET_BITS : jhmp_pkg::HLEN_W;

    logic [3:0]             r_mode, n_mode, e_mode;
    logic [15:0]            r_skip, n_skip, e_skip;
    logic [OFFSET_BITS-1:0] r_offset, n_offset, e_offset;
    logic [7:0]             r_len_hi, n_len_hi, e_len_hi;
    logic [15:0]            r_width, n_width, e_width;
    logic [15:0]            r_height, n_height, e_height;
    logic [15:0]            r_interval, n_interval, e_interval;
    logic                   r_type, n_type, e_type;
    logic [3:0]             r_prec, n_prec, e_prec;
    logic                   r_tsel, n_tsel, e_tsel;
    logic [7:0]             r_tcount, n_tcount, e_tcount;
    logic                   r_finished, n_finished, e_finished;

    logic [15:0]            v_rec;
    logic [OFFSET_BITS-1:0] v_sum;
    logic [EXT_W-1:0]       v_ext;
    logic                   v_tvalid, v_done, v_scan, v_quiet;
    logic [7:0]             v_tlimit;

    always_comb begin
        // a frame start clears the parse state before its byte is handled
        e_mode     = i_frame_start ? MODE_SCAN : r_mode;
        e_skip     = i_frame_start ? '0 : r_skip;
        e_offset   = i_frame_start ? '0 : r_offset;
        e_len_hi   = i_frame_start ? '0 : r_len_hi;
        e_width    = i_frame_start ? '0 : r_width;
        e_height   = i_frame_start ? '0 : r_height;
        e_interval = i_frame_start ? '0 : r_interval;
        e_type     = i_frame_start ? 1'b0 : r_type;
        e_prec     = i_frame_start ? '0 : r_prec;
        e_tsel     = i_frame_start ? 1'b0 : r_tsel;
        e_tcount   = i_frame_start ? '0 : r_tcount;
        e_finished = i_frame_start ? 1'b0 : r_finished;

        n_mode     = e_mode;
        n_skip     = e_skip;
        n_offset   = e_offset;
        n_len_hi   = e_len_hi;
        n_width    = e_width;
        n_height   = e_height;
        n_interval = e_interval;
        n_type     = e_type;
        n_prec     = e_prec;
        n_tsel     = e_tsel;
        n_tcount   = e_tcount;
        n_finished = e_finished;

        v_tvalid = 1'b0;
        v_done   = 1'b0;
        v_scan   = 1'b0;
        v_quiet  = 1'b0;
        v_rec    = {e_len_hi, i_data_byte};
        v_sum    = e_offset + OFFSET_BITS'(v_rec) - OFFSET_BITS'(1);
        v_ext    = EXT_W'(v_sum);
        v_tlimit = (e_prec != 4'd0) ? jhmp_pkg::TABLE_LEN_16BIT : jhmp_pkg::TABLE_LEN_8BIT;

        o_res = '0;

        if (!e_finished) begin
            n_offset = e_offset + OFFSET_BITS'(1);
            unique case (e_mode)
                MODE_MARK: begin
                    n_skip = '0;
                    if (i_data_byte == jhmp_pkg::MARKER_DQT) begin
                        n_mode = MODE_DQT;
                    end else if (i_data_byte == jhmp_pkg::MARKER_DHT) begin
                        n_mode = MODE_DHT;
                    end else if (i_data_byte == jhmp_pkg::MARKER_SOF) begin
                        n_mode = MODE_SOF;
                    end else if (i_data_byte == jhmp_pkg::MARKER_DRI) begin
                        n_mode = MODE_DRI;
                    end else if (i_data_byte == jhmp_pkg::MARKER_SOS) begin
                        n_mode = MODE_SOS;
                    end else if (i_data_byte == jhmp_pkg::MARKER_EOI) begin
                        v_done = 1'b1;
                        n_mode = MODE_SCAN;
                    end else begin
                        n_mode = (i_data_byte == jhmp_pkg::BYTE_FF) ? MODE_MARK : MODE_SCAN;
                    end
                end
                MODE_DQT: begin
                    if (e_skip < 16'd2) begin
                        n_skip = e_skip + 16'd1;
                    end else begin
                        n_prec   = i_data_byte[7:4];
                        n_tsel   = |i_data_byte[3:0];
                        n_tcount = '0;
                        n_mode   = MODE_TABLE;
                    end
                end
                MODE_TABLE: begin
                    v_tvalid = 1'b1;
                    n_tcount = e_tcount + 8'd1;
                    if (n_tcount >= v_tlimit) begin
                        n_mode = MODE_SCAN;
                    end
                end
                MODE_DHT: begin
                    if (e_skip == 16'd0) begin
                        n_len_hi = i_data_byte;
                        n_skip   = 16'd1;
                    end else if (v_rec > 16'd2) begin
                        n_skip = v_rec - 16'd2;
                        n_mode = MODE_SKIP;
                    end else begin
                        n_skip = '0;
                        n_mode = MODE_SCAN;
                    end
                end
                MODE_SKIP: begin
                    if (e_skip != 16'd0) begin
                        n_skip = e_skip - 16'd1;
                    end
                    if (n_skip == 16'd0) begin
                        n_mode = MODE_SCAN;
                    end
                end
                MODE_SOF: begin
                    case (e_skip)
                        16'd3, 16'd5: n_len_hi = i_data_byte;
                        16'd4:        n_height = v_rec;
                        16'd6:        n_width  = v_rec;
                        16'd9: begin
                            if (i_data_byte == jhmp_pkg::SAMP_422) begin
                                n_type = 1'b0;
                            end else if (i_data_byte == jhmp_pkg::SAMP_420) begin
                                n_type = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (e_skip == 16'd7 && i_data_byte != 8'd3) begin
                        // component count other than three: rescan it as plain data
                        v_quiet = 1'b1;
                        n_skip  = '0;
                        n_mode  = (i_data_byte == jhmp_pkg::BYTE_FF) ? MODE_MARK : MODE_SCAN;
                    end else if (e_skip >= 16'd16) begin
                        n_skip = '0;
                        n_mode = MODE_SCAN;
                    end else begin
                        n_skip = e_skip + 16'd1;
                    end
                end
                MODE_DRI: begin
                    if (e_skip == 16'd2) begin
                        n_len_hi = i_data_byte;
                    end
                    if (e_skip == 16'd3) begin
                        n_interval = v_rec;
                        n_skip     = '0;
                        n_mode     = MODE_SCAN;
                    end else begin
                        n_skip = e_skip + 16'd1;
                    end
                end
                MODE_SOS: begin
                    if (e_skip == 16'd0) begin
                        n_len_hi = i_data_byte;
                        n_skip   = 16'd1;
                    end else begin
                        v_done = 1'b1;
                        v_scan = 1'b1;
                        n_skip = '0;
                        n_mode = MODE_SCAN;
                    end
                end
                default: begin
                    n_mode = (i_data_byte == jhmp_pkg::BYTE_FF) ? MODE_MARK : MODE_SCAN;
                end
            endcase
            if (!v_quiet && i_frame_end) begin
                v_done = 1'b1;
            end
            if (v_done) begin
                n_finished = 1'b1;
            end
        end

        if (v_tvalid) begin
            o_res.table_byte_valid = 1'b1;
            o_res.table_select     = e_tsel;
            o_res.table_position   = e_tcount[6:0];
            o_res.table_value      = i_data_byte;
        end
        if (v_done) begin
            o_res.header_done      = 1'b1;
            o_res.scan_found       = v_scan;
            o_res.frame_width      = n_width;
            o_res.frame_height     = n_height;
            o_res.sampling_type    = n_type;
            o_res.restart_interval = n_interval;
            o_res.table_precision  = n_prec;
            o_res.header_length    = v_scan ? v_ext[jhmp_pkg::HLEN_W-1:0] : '0;
        end
        o_res_valid = v_tvalid || v_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_SCAN;
            r_skip     <= '0;
            r_offset   <= '0;
            r_len_hi   <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_interval <= '0;
            r_type     <= 1'b0;
            r_prec     <= '0;
            r_tsel     <= 1'b0;
            r_tcount   <= '0;
            r_finished <= 1'b0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_skip     <= n_skip;
            r_offset   <= n_offset;
            r_len_hi   <= n_len_hi;
            r_width    <= n_width;
            r_height   <= n_height;
            r_interval <= n_interval;
            r_type     <= n_type;
            r_prec     <= n_prec;
            r_tsel     <= n_tsel;
            r_tcount   <= n_tcount;
            r_finished <= n_finished;
        end
    end

endmodule

`default_nettype wire

// ===== src/jhmp_out_buf.sv =====
// ----------------------------------------------------------------------------
// jhmp_out_buf
// Result register holding one beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module jhmp_out_buf (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load_valid,
    output logic                  o_load_ready,
    input  jhmp_pkg::t_result     i_load,
    output logic                  o_valid,
    input  wire                   i_ready,
    output jhmp_pkg::t_result     o_res
);

    logic              r_valid;
    jhmp_pkg::t_result r_res;

    assign o_load_ready = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_res        = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ready) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ready && i_load_valid) begin
            r_res <= i_load;
        end
    end

endmodule

`default_nettype wire
